/* src/stm_pkg.sv */
// ----------------------------------------------------------------------------
// stm_pkg: shared types and constants for the screen transition mask
// Holds the configuration record, the controller states and the command and
// status records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int DIM_W  = 13;
  localparam int STEP_W = 7;
  localparam int SQ_W   = 26;
  localparam int NUM_W  = DIM_W + STEP_W;

  localparam logic [DIM_W-1:0]  MAX_DIM    = 13'd4096;
  localparam logic [STEP_W-1:0] MAX_STAGES = 7'd64;

  localparam logic [SQ_W-1:0] SQRT_BIT0  = 26'h100_0000;
  localparam logic [4:0]      SQRT_STEPS = 5'd13;
  localparam logic [4:0]      DIV_STEPS  = 5'd20;

  localparam logic [2:0] SHAPE_IRIS  = 3'd0;
  localparam logic [2:0] SHAPE_BOX   = 3'd1;
  localparam logic [2:0] SHAPE_WIPE_RL = 3'd2;
  localparam logic [2:0] SHAPE_WIPE_LR = 3'd3;
  localparam logic [2:0] SHAPE_SPLIT = 3'd4;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SHAPE_KIND   = 3'd2;
  localparam logic [2:0] REG_FADE_IN      = 3'd3;
  localparam logic [2:0] REG_STEP_TOTAL   = 3'd4;
  localparam logic [2:0] REG_FILL_COLOR   = 3'd5;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_START   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [2:0]        shape_kind;
    logic              fade_in;
    logic [STEP_W-1:0] step_total;
    logic [31:0]       fill_color;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ0,
    ST_SQ1,
    ST_ROOT,
    ST_DIV_LD,
    ST_DIV,
    ST_STORE,
    ST_RSQ
  } stm_state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_SQ_MX,
    DP_SQ_MY,
    DP_ROOT_STEP,
    DP_DIV_LD,
    DP_DIV_STEP,
    DP_STORE,
    DP_RSQ
  } dp_op_t;

  typedef enum logic [1:0] {
    SRC_X,
    SRC_Y,
    SRC_R
  } src_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
    src_t   src;
  } dp_cmd_t;

  typedef struct packed {
    logic run_valid;
  } dp_sts_t;

  function automatic logic cfg_ok(cfg_t c);
    return (c.shape_kind <= SHAPE_SPLIT) && (c.step_total != '0) &&
           (c.step_total <= MAX_STAGES);
  endfunction

  function automatic logic run_ok(logic act, logic [STEP_W-1:0] step, cfg_t c);
    return act && cfg_ok(c) && (step != '0) && (step <= c.step_total);
  endfunction

endpackage

/* src/stm_ctrl.sv */
// ----------------------------------------------------------------------------
// stm_ctrl: handshake and stage-update sequencer
// Accepts items while idle, holds the result flag, and on a stage change or a
// register write runs square, root, three scaled divisions and a squaring.
// ----------------------------------------------------------------------------
module stm_ctrl
  import stm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_op,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  logic       cfg_go,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  stm_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  src_t       src_r, src_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      src_r       <= SRC_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
    accept    = in_tvalid && in_tready;
    go        = cfg_go || (accept && ((in_op == OP_ADVANCE) || (in_op == OP_START)));
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    src_nxt   = src_r;
    cmd.accept = accept;
    cmd.op     = DP_NOP;
    cmd.src    = src_r;
    case (state_r)
      ST_IDLE: begin
      end
      ST_CHECK: begin
        state_nxt = sts.run_valid ? ST_SQ0 : ST_IDLE;
      end
      ST_SQ0: begin
        cmd.op    = DP_SQ_MX;
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.op    = DP_SQ_MY;
        cnt_nxt   = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.op  = DP_ROOT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == SQRT_STEPS - 5'd1) begin
          src_nxt   = SRC_X;
          state_nxt = ST_DIV_LD;
        end
      end
      ST_DIV_LD: begin
        cmd.op    = DP_DIV_LD;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_STEPS - 5'd1) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.op = DP_STORE;
        case (src_r)
          SRC_X: begin
            src_nxt   = SRC_Y;
            state_nxt = ST_DIV_LD;
          end
          SRC_Y: begin
            src_nxt   = SRC_R;
            state_nxt = ST_DIV_LD;
          end
          default: begin
            state_nxt = ST_RSQ;
          end
        endcase
      end
      ST_RSQ: begin
        cmd.op    = DP_RSQ;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // restart the update on a start, an advance or any register write
    if (go) state_nxt = ST_CHECK;
    if (accept) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

/* src/stm_dp.sv */
// ----------------------------------------------------------------------------
// stm_dp: transition state, stage extents and pixel masking
// Keeps the stage counter and extents, runs the shared root and divider
// steps on command, and registers one result per accepted item.
// ----------------------------------------------------------------------------
module stm_dp
  import stm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [31:0] in_pixel,
  output logic [31:0] out_pixel,
  output logic        out_masked,
  output logic        out_running,
  output dp_sts_t     sts
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              active_r, active_nxt;
  logic [DIM_W-1:0]  ext_x_r, ext_y_r, rad_r;
  logic [SQ_W-1:0]   iris_r;
  logic [SQ_W-1:0]   prod_r, sv_r, res_r, bit_r;
  logic [NUM_W-1:0]  num_r;
  logic [STEP_W-1:0] rem_r;
  logic [31:0]       pix_r;
  logic              masked_r, running_r;

  logic [DIM_W-1:0]  w, h, mx, my, root_ceil, div_src;
  logic              rv, running;
  logic [DIM_W:0]    ax, bx, ay, by;
  logic [DIM_W-1:0]  dx, dy;
  logic [SQ_W:0]     dist_sq;
  logic              in_frame, ins, masked;
  logic [31:0]       pix_res;
  logic [SQ_W:0]     trial;
  logic [STEP_W:0]   tr;
  logic              qbit;

  always_comb begin
    w  = (cfg.frame_width > MAX_DIM) ? MAX_DIM : cfg.frame_width;
    h  = (cfg.frame_height > MAX_DIM) ? MAX_DIM : cfg.frame_height;
    mx = (w != '0) ? w - 13'd1 : '0;
    my = (h != '0) ? h - 13'd1 : '0;
    rv = run_ok(active_r, step_r, cfg);
    sts.run_valid = rv;

    active_nxt = active_r;
    step_nxt   = step_r;
    if (cmd.accept) begin
      case (in_op)
        OP_ADVANCE: begin
          if (rv) begin
            if (step_r == cfg.step_total) active_nxt = 1'b0;
            else step_nxt = step_r + 7'd1;
          end
        end
        OP_START: begin
          if (cfg_ok(cfg)) begin
            step_nxt   = 7'd1;
            active_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    running = run_ok(active_nxt, step_nxt, cfg);

    // distances in doubled units from the frame center
    ax = {1'b0, in_pos_x, 1'b1};
    bx = {1'b0, w};
    ay = {1'b0, in_pos_y, 1'b1};
    by = {1'b0, h};
    dx = (ax >= bx) ? DIM_W'(ax - bx) : DIM_W'(bx - ax);
    dy = (ay >= by) ? DIM_W'(ay - by) : DIM_W'(by - ay);
    dist_sq = (SQ_W+1)'(dx) * (SQ_W+1)'(dx) + (SQ_W+1)'(dy) * (SQ_W+1)'(dy);
    in_frame = ({1'b0, in_pos_x} < w) && ({1'b0, in_pos_y} < h);
    case (cfg.shape_kind)
      SHAPE_IRIS:    ins = dist_sq <= {1'b0, iris_r};
      SHAPE_BOX:     ins = (dx < ext_x_r) && (dy < ext_y_r);
      SHAPE_WIPE_RL: ins = (ext_x_r >= w) || ({1'b0, in_pos_x} >= w - ext_x_r);
      SHAPE_WIPE_LR: ins = {1'b0, in_pos_x} < ext_x_r;
      SHAPE_SPLIT:   ins = dx < ext_x_r;
      default:       ins = 1'b0;
    endcase
    masked  = (in_op == OP_PIXEL) && rv && in_frame && (cfg.fade_in ? !ins : ins);
    pix_res = (in_op != OP_PIXEL) ? 32'd0 : (masked ? cfg.fill_color : in_pixel);

    trial     = {1'b0, res_r} + {1'b0, bit_r};
    root_ceil = res_r[DIM_W-1:0] + {{(DIM_W-1){1'b0}}, (sv_r != '0)};
    case (cmd.src)
      SRC_X:   div_src = w;
      SRC_Y:   div_src = h;
      default: div_src = root_ceil;
    endcase
    tr   = {rem_r, num_r[NUM_W-1]};
    qbit = tr >= {1'b0, cfg.step_total};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      active_r <= 1'b0;
      ext_x_r  <= '0;
      ext_y_r  <= '0;
      iris_r   <= '0;
    end else begin
      step_r   <= step_nxt;
      active_r <= active_nxt;
      case (cmd.op)
        DP_STORE: begin
          case (cmd.src)
            SRC_X:   ext_x_r <= num_r[DIM_W-1:0];
            SRC_Y:   ext_y_r <= num_r[DIM_W-1:0];
            default: begin
            end
          endcase
        end
        DP_RSQ:  iris_r <= SQ_W'(rad_r) * SQ_W'(rad_r);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r     <= pix_res;
      masked_r  <= masked;
      running_r <= running;
    end
    case (cmd.op)
      DP_SQ_MX: prod_r <= SQ_W'(mx) * SQ_W'(mx);
      DP_SQ_MY: begin
        sv_r  <= prod_r + SQ_W'(my) * SQ_W'(my);
        res_r <= '0;
        bit_r <= SQRT_BIT0;
      end
      DP_ROOT_STEP: begin
        if ({1'b0, sv_r} >= trial) begin
          sv_r  <= sv_r - trial[SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      DP_DIV_LD: begin
        num_r <= NUM_W'(div_src) * NUM_W'(step_r) + NUM_W'(cfg.step_total - 7'd1);
        rem_r <= '0;
      end
      DP_DIV_STEP: begin
        rem_r <= qbit ? STEP_W'(tr - {1'b0, cfg.step_total}) : tr[STEP_W-1:0];
        num_r <= {num_r[NUM_W-2:0], qbit};
      end
      DP_STORE: begin
        if (cmd.src == SRC_R) rad_r <= num_r[DIM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_pixel   = pix_r;
  assign out_masked  = masked_r;
  assign out_running = running_r;

endmodule

/* src/screen_transition_mask_top.sv */
// ----------------------------------------------------------------------------
// screen_transition_mask_top: pixel-stream wipe generator
// Masks pixels inside or outside an iris, box, wipe or split shape.
//
// Input stream: in_tuser carries the op (pixel, advance, start, none); in_tdata
// carries the pixel column, row and value. Every transfer yields exactly one
// result transfer: the masked or passed pixel (zero for other ops) in
// out_tdata, and the masked and running flags in out_tuser.
// The result is registered and valid in the cycle after the input transfer.
// Pixel items sustain one per cycle while the receiver keeps up and no update
// runs; the result register frees on the same edge it is taken.
// After a start, an advance or a register write the block recomputes the
// stage extents: a check, two square steps, 13 root steps, three scaled
// divisions and a final squaring, during which in_tready stays low. The
// root and divider units are shared across these steps.
// Registers are written over the APB-style port and read back at once.
// Reset clears the stage state and loads the register defaults; no result
// is pending afterwards. When the receiver stalls, the result holds and no
// new item is taken until it leaves.
// ----------------------------------------------------------------------------
module screen_transition_mask_top
  import stm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // pos_x[11:0], pos_y[23:12], pixel_in[55:24]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_out[31:0]
  output logic [1:0]  out_tuser,  // was_masked[0], running[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       cfg_go;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_go  = wr_en && (reg_idx <= REG_FILL_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= 13'd640;
      cfg_r.frame_height <= 13'd480;
      cfg_r.shape_kind   <= SHAPE_IRIS;
      cfg_r.fade_in      <= 1'b0;
      cfg_r.step_total   <= 7'd16;
      cfg_r.fill_color   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[DIM_W-1:0];
        REG_SHAPE_KIND:   cfg_r.shape_kind   <= pwdata[2:0];
        REG_FADE_IN:      cfg_r.fade_in      <= pwdata[0];
        REG_STEP_TOTAL:   cfg_r.step_total   <= pwdata[STEP_W-1:0];
        REG_FILL_COLOR:   cfg_r.fill_color   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {19'd0, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, cfg_r.frame_height};
      REG_SHAPE_KIND:   prdata = {29'd0, cfg_r.shape_kind};
      REG_FADE_IN:      prdata = {31'd0, cfg_r.fade_in};
      REG_STEP_TOTAL:   prdata = {25'd0, cfg_r.step_total};
      REG_FILL_COLOR:   prdata = cfg_r.fill_color;
      default:          prdata = '0;
    endcase
  end

  stm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_go     (cfg_go),
    .sts        (sts),
    .cmd        (cmd)
  );

  stm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .in_op       (in_tuser),
    .in_pos_x    (in_tdata[11:0]),
    .in_pos_y    (in_tdata[23:12]),
    .in_pixel    (in_tdata[55:24]),
    .out_pixel   (out_tdata),
    .out_masked  (out_tuser[0]),
    .out_running (out_tuser[1]),
    .sts         (sts)
  );

endmodule

/* src/stm_chk.sv */
// ----------------------------------------------------------------------------
// stm_chk: port-level checks for the screen transition mask
// Watches the stream ports for result ordering and flag consistency.
// ----------------------------------------------------------------------------
module stm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // every input transfer leaves a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer without result");

  // masking only happens while a transition runs
  a_mask_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("masked pixel without running transition");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind screen_transition_mask_top stm_chk u_stm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
